>>> design/iem_pkg.sv
`default_nettype none

package iem_pkg;

  localparam logic [6:0] DEV_SEL_RST = 7'h50;

  localparam logic [2:0] FUNC_NONE       = 3'd0;
  localparam logic [2:0] FUNC_READ       = 3'd1;
  localparam logic [2:0] FUNC_WRITE_STOP = 3'd2;
  localparam logic [2:0] FUNC_WRITE_OPEN = 3'd3;
  localparam logic [2:0] FUNC_CONT       = 3'd4;
  localparam logic [2:0] FUNC_CONT_STOP  = 3'd5;

  typedef enum logic [4:0] {
    PH_IDLE, PH_STOP0, PH_STOP1, PH_STOP2, PH_START0, PH_START1,
    PH_SPRE, PH_SBIT0, PH_SBIT1, PH_SBIT2,
    PH_ACK0, PH_ACK1, PH_ACK2, PH_ACK3, PH_ACK4,
    PH_RX0, PH_RX1, PH_RX2, PH_RX3, PH_RX4, PH_MACK
  } phase_e;

  typedef enum logic [2:0] {
    ROLE_CTRLW, ROLE_ADDRH, ROLE_ADDRL, ROLE_CTRLR, ROLE_DATA, ROLE_READ, ROLE_FINAL
  } role_e;

  typedef struct packed {
    logic [2:0]  func;
    logic [15:0] mem_address;
    logic [7:0]  byte_count;
    logic [7:0]  wr_data;
    logic        wr_valid;
    logic        sda_in;
  } cmd_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       sda_released;
    logic [7:0] rd_data;
    logic       rd_valid;
    logic       rd_last;
    logic       byte_taken;
    logic       busy_res;
    logic       done_res;
  } res_t;

endpackage

`default_nettype wire

>>> design/iem_if.sv
`default_nettype none

interface iem_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  func;
  logic [15:0] mem_address;
  logic [7:0]  byte_count;
  logic [7:0]  wr_data;
  logic        wr_valid;
  logic        sda_in;

  modport source (output valid, func, mem_address, byte_count, wr_data, wr_valid, sda_in,
                  input ready);
  modport sink   (input valid, func, mem_address, byte_count, wr_data, wr_valid, sda_in,
                  output ready);
endinterface

interface iem_out_if;
  logic       valid;
  logic       ready;
  logic       scl_level;
  logic       sda_level;
  logic       sda_released;
  logic [7:0] rd_data;
  logic       rd_valid;
  logic       rd_last;
  logic       byte_taken;
  logic       busy_res;
  logic       done_res;

  modport source (output valid, scl_level, sda_level, sda_released, rd_data, rd_valid,
                         rd_last, byte_taken, busy_res, done_res,
                  input ready);
  modport sink   (input valid, scl_level, sda_level, sda_released, rd_data, rd_valid,
                        rd_last, byte_taken, busy_res, done_res,
                  output ready);
endinterface

interface iem_cfg_if;
  logic       valid;
  logic       ready;
  logic [6:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

>>> design/iem_seq.sv
`default_nettype none

module iem_seq
  import iem_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       step_i,
  input  wire cmd_t       cmd_i,
  input  wire logic [6:0] dev_sel_i,
  output      res_t       res_o
);

  phase_e     phase_q, phase_d, ph_a;
  role_e      role_q, role_d, role_a;
  logic [7:0] shift_q, shift_d;
  logic [3:0] bit_q, bit_d;
  logic [7:0] bytes_q, bytes_d, bytes_a;
  logic [7:0] addr_hi_q, addr_hi_d, addr_hi_a;
  logic [7:0] addr_lo_q, addr_lo_d, addr_lo_a;
  logic       rd_mode_q, rd_mode_d, rd_mode_a;
  logic       stop_end_q, stop_end_d, stop_end_a;
  logic       open_q, open_d, open_a;
  logic       fin_a;

  logic [7:0] ctrl_wr, ctrl_rd;
  logic       nack;
  logic [3:0] bit_inc;

  assign ctrl_wr = {dev_sel_i, 1'b0};
  assign ctrl_rd = {dev_sel_i, 1'b1};
  assign nack    = shift_q[0];
  assign bit_inc = bit_q + 4'd1;

  // command launch at an idle tick; the launched phase runs in the same tick
  always_comb begin
    ph_a       = phase_q;
    role_a     = role_q;
    bytes_a    = bytes_q;
    addr_hi_a  = addr_hi_q;
    addr_lo_a  = addr_lo_q;
    rd_mode_a  = rd_mode_q;
    stop_end_a = stop_end_q;
    open_a     = open_q;
    fin_a      = 1'b0;
    if (phase_q == PH_IDLE) begin
      if (cmd_i.func == FUNC_READ || cmd_i.func == FUNC_WRITE_STOP ||
          cmd_i.func == FUNC_WRITE_OPEN) begin
        rd_mode_a  = (cmd_i.func == FUNC_READ);
        stop_end_a = (cmd_i.func != FUNC_WRITE_OPEN);
        bytes_a    = (cmd_i.func == FUNC_READ && cmd_i.byte_count == 8'd0) ? 8'd1
                                                                           : cmd_i.byte_count;
        addr_hi_a  = cmd_i.mem_address[15:8];
        addr_lo_a  = cmd_i.mem_address[7:0];
        open_a     = 1'b0;
        role_a     = ROLE_CTRLW;
        ph_a       = PH_STOP0;
      end else if ((cmd_i.func == FUNC_CONT || cmd_i.func == FUNC_CONT_STOP) && open_q) begin
        rd_mode_a  = 1'b0;
        stop_end_a = (cmd_i.func == FUNC_CONT_STOP);
        bytes_a    = cmd_i.byte_count;
        open_a     = 1'b0;
        if (cmd_i.byte_count != 8'd0) begin
          role_a = ROLE_DATA;
          ph_a   = PH_SPRE;
        end else if (cmd_i.func == FUNC_CONT_STOP) begin
          role_a = ROLE_FINAL;
          ph_a   = PH_STOP0;
        end else begin
          open_a = 1'b1;
          fin_a  = 1'b1;
        end
      end
    end
  end

  // next state
  always_comb begin
    logic [7:0] bytes_n;
    bytes_n    = bytes_a;
    phase_d    = ph_a;
    role_d     = role_a;
    bytes_d    = bytes_a;
    addr_hi_d  = addr_hi_a;
    addr_lo_d  = addr_lo_a;
    rd_mode_d  = rd_mode_a;
    stop_end_d = stop_end_a;
    open_d     = open_a;
    shift_d    = shift_q;
    bit_d      = bit_q;
    case (ph_a)
      PH_IDLE:   phase_d = PH_IDLE;
      PH_STOP0:  phase_d = PH_STOP1;
      PH_STOP1:  phase_d = PH_STOP2;
      PH_STOP2: begin
        if (role_a == ROLE_CTRLW) begin
          phase_d = PH_START0;
        end else begin
          phase_d = PH_IDLE;
          open_d  = 1'b0;
        end
      end
      PH_START0: phase_d = PH_START1;
      PH_START1: begin
        shift_d = (role_a == ROLE_CTRLR) ? ctrl_rd : ctrl_wr;
        bit_d   = 4'd0;
        phase_d = PH_SPRE;
      end
      PH_SPRE: begin
        if (role_a != ROLE_DATA) begin
          phase_d = PH_SBIT0;
        end else if (cmd_i.wr_valid) begin
          shift_d = cmd_i.wr_data;
          bit_d   = 4'd0;
          phase_d = PH_SBIT0;
        end
      end
      PH_SBIT0:  phase_d = PH_SBIT1;
      PH_SBIT1:  phase_d = PH_SBIT2;
      PH_SBIT2: begin
        shift_d = {shift_q[6:0], 1'b0};
        bit_d   = bit_inc;
        phase_d = bit_inc[3] ? PH_ACK0 : PH_SBIT0;
      end
      PH_ACK0:   phase_d = PH_ACK1;
      PH_ACK1:   phase_d = PH_ACK2;
      PH_ACK2: begin
        shift_d = {7'd0, cmd_i.sda_in};
        phase_d = PH_ACK3;
      end
      PH_ACK3:   phase_d = PH_ACK4;
      PH_ACK4: begin
        case (role_a)
          ROLE_CTRLW: begin
            if (nack) begin
              phase_d = PH_STOP0;
            end else begin
              role_d  = ROLE_ADDRH;
              shift_d = addr_hi_a;
              bit_d   = 4'd0;
              phase_d = PH_SPRE;
            end
          end
          ROLE_ADDRH: begin
            if (nack) begin
              role_d  = ROLE_CTRLW;
              phase_d = PH_STOP0;
            end else begin
              role_d  = ROLE_ADDRL;
              shift_d = addr_lo_a;
              bit_d   = 4'd0;
              phase_d = PH_SPRE;
            end
          end
          ROLE_CTRLR: begin
            if (nack) begin
              phase_d = PH_START0;
            end else begin
              role_d  = ROLE_READ;
              shift_d = 8'd0;
              bit_d   = 4'd0;
              phase_d = PH_RX0;
            end
          end
          default: begin
            if (role_a == ROLE_ADDRL && nack) begin
              role_d  = ROLE_CTRLW;
              phase_d = PH_STOP0;
            end else if (role_a == ROLE_ADDRL && rd_mode_a) begin
              role_d  = ROLE_CTRLR;
              phase_d = PH_START0;
            end else if (role_a != ROLE_ADDRL && nack) begin
              // data byte refused: clock the ACK bit again
              phase_d = PH_ACK0;
            end else begin
              if (role_a != ROLE_ADDRL && bytes_a != 8'd0) begin
                bytes_n = bytes_a - 8'd1;
              end
              bytes_d = bytes_n;
              if (bytes_n != 8'd0) begin
                role_d  = ROLE_DATA;
                phase_d = PH_SPRE;
              end else if (stop_end_a) begin
                role_d  = ROLE_FINAL;
                phase_d = PH_STOP0;
              end else begin
                phase_d = PH_IDLE;
                open_d  = 1'b1;
              end
            end
          end
        endcase
      end
      PH_RX0:    phase_d = PH_RX1;
      PH_RX1:    phase_d = PH_RX2;
      PH_RX2: begin
        shift_d = {shift_q[6:0], cmd_i.sda_in};
        phase_d = PH_RX3;
      end
      PH_RX3:    phase_d = PH_RX4;
      PH_RX4: begin
        bit_d   = bit_inc;
        phase_d = bit_inc[3] ? PH_MACK : PH_RX0;
      end
      PH_MACK: begin
        if (bytes_a > 8'd1) begin
          bytes_d = bytes_a - 8'd1;
          shift_d = 8'd0;
          bit_d   = 4'd0;
          phase_d = PH_RX0;
        end else begin
          role_d  = ROLE_FINAL;
          phase_d = PH_STOP0;
        end
      end
      default:   phase_d = PH_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    res_o = '0;
    res_o.busy_res = 1'b1;
    case (ph_a)
      PH_IDLE: begin
        res_o.busy_res  = fin_a;
        res_o.sda_level = !fin_a && !open_a;
      end
      PH_STOP0, PH_SPRE, PH_ACK4, PH_RX4: begin
        res_o.scl_level = 1'b0;
        res_o.byte_taken = (ph_a == PH_SPRE) && (role_a == ROLE_DATA) && cmd_i.wr_valid;
      end
      PH_STOP1, PH_START1: begin
        res_o.scl_level = 1'b1;
      end
      PH_STOP2, PH_START0: begin
        res_o.scl_level = 1'b1;
        res_o.sda_level = 1'b1;
      end
      PH_SBIT0, PH_SBIT2: begin
        res_o.sda_level = shift_q[7];
      end
      PH_SBIT1: begin
        res_o.scl_level = 1'b1;
        res_o.sda_level = shift_q[7];
      end
      PH_ACK0, PH_ACK3, PH_RX0, PH_RX3: begin
        res_o.sda_level    = 1'b1;
        res_o.sda_released = 1'b1;
      end
      PH_ACK1, PH_ACK2, PH_RX1: begin
        res_o.scl_level    = 1'b1;
        res_o.sda_level    = 1'b1;
        res_o.sda_released = 1'b1;
      end
      PH_RX2: begin
        res_o.scl_level    = 1'b1;
        res_o.sda_level    = 1'b1;
        res_o.sda_released = 1'b1;
        if (bit_q == 4'd7) begin
          res_o.rd_valid = 1'b1;
          res_o.rd_data  = {shift_q[6:0], cmd_i.sda_in};
          res_o.rd_last  = (bytes_a <= 8'd1);
        end
      end
      PH_MACK: begin
        res_o.scl_level = 1'b1;
        res_o.sda_level = (bytes_a <= 8'd1);
      end
      default: begin
        res_o.busy_res  = 1'b0;
        res_o.sda_level = 1'b1;
      end
    endcase
    // a command ends on the tick the sequencer falls back to idle
    res_o.done_res = res_o.busy_res && (phase_d == PH_IDLE);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_IDLE;
      role_q     <= ROLE_CTRLW;
      shift_q    <= 8'd0;
      bit_q      <= 4'd0;
      bytes_q    <= 8'd0;
      addr_hi_q  <= 8'd0;
      addr_lo_q  <= 8'd0;
      rd_mode_q  <= 1'b0;
      stop_end_q <= 1'b0;
      open_q     <= 1'b0;
    end else if (step_i) begin
      phase_q    <= phase_d;
      role_q     <= role_d;
      shift_q    <= shift_d;
      bit_q      <= bit_d;
      bytes_q    <= bytes_d;
      addr_hi_q  <= addr_hi_d;
      addr_lo_q  <= addr_lo_d;
      rd_mode_q  <= rd_mode_d;
      stop_end_q <= stop_end_d;
      open_q     <= open_d;
    end
  end

endmodule

`default_nettype wire

>>> design/i2c_eeprom_master.sv
// Result of an accepted tick item: registered, on res_o in the cycle after the transfer.
// Throughput: one item per cycle while res_o is ready; the sequencer steps per item;
//   the result register frees the input side as soon as its content is taken.
// Reset (rst_ni low, asynchronous): sequencer idle with no open write, result register
//   empty, device_select back to 0x50.
`default_nettype none

module i2c_eeprom_master
  import iem_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  iem_in_if.sink    in_i,
  iem_out_if.source res_o,
  iem_cfg_if.sink   cfg_i
);

  logic [6:0] dev_sel_q;
  logic       out_vld_q;
  res_t       res_q;
  res_t       res;
  cmd_t       cmd;
  logic       step;

  assign cmd = '{func:        in_i.func,
                 mem_address: in_i.mem_address,
                 byte_count:  in_i.byte_count,
                 wr_data:     in_i.wr_data,
                 wr_valid:    in_i.wr_valid,
                 sda_in:      in_i.sda_in};

  assign in_i.ready  = !out_vld_q || res_o.ready;
  assign step        = in_i.valid && in_i.ready;
  assign cfg_i.ready = 1'b1;

  iem_seq u_seq (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (step),
    .cmd_i     (cmd),
    .dev_sel_i (dev_sel_q),
    .res_o     (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dev_sel_q <= DEV_SEL_RST;
    end else if (cfg_i.valid) begin
      dev_sel_q <= cfg_i.data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (step) begin
      out_vld_q <= 1'b1;
    end else if (res_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      res_q <= res;
    end
  end

  assign res_o.valid        = out_vld_q;
  assign res_o.scl_level    = res_q.scl_level;
  assign res_o.sda_level    = res_q.sda_level;
  assign res_o.sda_released = res_q.sda_released;
  assign res_o.rd_data      = res_q.rd_data;
  assign res_o.rd_valid     = res_q.rd_valid;
  assign res_o.rd_last      = res_q.rd_last;
  assign res_o.byte_taken   = res_q.byte_taken;
  assign res_o.busy_res     = res_q.busy_res;
  assign res_o.done_res     = res_q.done_res;

endmodule

`default_nettype wire
